FILE: rtl/salsa20_key_expand_core_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SALSA20_KEY_EXPAND_CORE_ASSERT_SVH
`define SALSA20_KEY_EXPAND_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define S20KE_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define S20KE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays armed through reset.
`define S20KE_ASSERT_NEXT_RST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/s20ke_pkg.sv
`default_nettype none

package s20ke_pkg;

    localparam int unsigned S20KE_DOUBLE_ROUNDS = 10;
    localparam int unsigned S20KE_STEPS_PER_DOUBLE_ROUND = 8;

    typedef logic [31:0] word_t;
    typedef logic [3:0] widx_t;
    typedef logic [15:0][31:0] state_t;

    typedef struct packed {
        logic [63:0] seed_w3;
        logic [63:0] seed_w2;
        logic [63:0] seed_w1;
        logic [63:0] seed_w0;
    } seed_t;

    typedef struct packed {
        logic [63:0] out_w7;
        logic [63:0] out_w6;
        logic [63:0] out_w5;
        logic [63:0] out_w4;
        logic [63:0] out_w3;
        logic [63:0] out_w2;
        logic [63:0] out_w1;
        logic [63:0] out_w0;
    } result_t;

    // "expand 16-byte k" as little-endian words
    localparam word_t TAU0 = 32'h6170_7865;
    localparam word_t TAU1 = 32'h3120_646e;
    localparam word_t TAU2 = 32'h7962_2d36;
    localparam word_t TAU3 = 32'h6b20_6574;

    // Word indexes of roles a, b, c, d for each quarter-round;
    // first index selects column round (0) or row round (1).
    localparam widx_t QIDX [2][4][4] = '{
        '{'{4'd0,  4'd4,  4'd8,  4'd12},
          '{4'd5,  4'd9,  4'd13, 4'd1},
          '{4'd10, 4'd14, 4'd2,  4'd6},
          '{4'd15, 4'd3,  4'd7,  4'd11}},
        '{'{4'd0,  4'd1,  4'd2,  4'd3},
          '{4'd5,  4'd6,  4'd7,  4'd4},
          '{4'd10, 4'd11, 4'd8,  4'd9},
          '{4'd15, 4'd12, 4'd13, 4'd14}}
    };

    // Rotation of each add-rotate-xor step of a quarter-round
    localparam int unsigned ROT_AMT [4] = '{7, 9, 13, 18};

    function automatic word_t rotl32(input word_t v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // Build the sixteen-word input block from a seed
    function automatic state_t init_block(input seed_t sd);
        state_t blk;
        blk[0]  = TAU0;
        blk[1]  = sd.seed_w2[31:0];
        blk[2]  = sd.seed_w2[63:32];
        blk[3]  = sd.seed_w3[31:0];
        blk[4]  = sd.seed_w3[63:32];
        blk[5]  = TAU1;
        blk[6]  = sd.seed_w0[31:0];
        blk[7]  = sd.seed_w0[63:32];
        blk[8]  = sd.seed_w1[31:0];
        blk[9]  = sd.seed_w1[63:32];
        blk[10] = TAU2;
        blk[11] = sd.seed_w2[31:0];
        blk[12] = sd.seed_w2[63:32];
        blk[13] = sd.seed_w3[31:0];
        blk[14] = sd.seed_w3[63:32];
        blk[15] = TAU3;
        return blk;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/salsa20_key_expand_core.sv
// A seed passes through the chain of cells and then the output register before m_valid.
// Throughput: one seed per cycle while the chain is not held; each round step is one cell of the chain.
// The whole chain holds only while a finished result waits and m_ready is low.
// Reset (aresetn low, synchronous) clears all stage valid bits; data is not reset.
`default_nettype none

module salsa20_key_expand_core
    import s20ke_pkg::*;
#(
    parameter int unsigned DOUBLE_ROUNDS = S20KE_DOUBLE_ROUNDS
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire seed_t   s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    localparam int unsigned NCELLS = S20KE_STEPS_PER_DOUBLE_ROUND * DOUBLE_ROUNDS;

    logic    ce;
    logic    vld [NCELLS+1];
    state_t  st  [NCELLS+1];
    seed_t   sd  [NCELLS+1];
    state_t  init_tail;
    state_t  fin;
    result_t result_next;
    result_t result_reg;
    logic    m_valid_reg;

    // Advance whenever the output register is free or being drained
    assign ce      = !m_valid_reg || m_ready;
    assign s_ready = ce;

    // Feed the chain with the freshly built input block
    assign vld[0] = s_valid;
    assign st[0]  = init_block(s_data);
    assign sd[0]  = s_data;

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        s20ke_cell #(
            .ROW_ROUND (((i / 4) % 2) == 1),
            .STEP      (i % 4)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .in_valid  (vld[i]),
            .in_state  (st[i]),
            .in_seed   (sd[i]),
            .out_valid (vld[i+1]),
            .out_state (st[i+1]),
            .out_seed  (sd[i+1])
        );
    end

    // Add the input block back and pack words little-endian
    always_comb begin
        init_tail = init_block(sd[NCELLS]);
        for (int w = 0; w < 16; w++) begin
            fin[w] = st[NCELLS][w] + init_tail[w];
        end
        result_next.out_w0 = {fin[1],  fin[0]};
        result_next.out_w1 = {fin[3],  fin[2]};
        result_next.out_w2 = {fin[5],  fin[4]};
        result_next.out_w3 = {fin[7],  fin[6]};
        result_next.out_w4 = {fin[9],  fin[8]};
        result_next.out_w5 = {fin[11], fin[10]};
        result_next.out_w6 = {fin[13], fin[12]};
        result_next.out_w7 = {fin[15], fin[14]};
    end

    // Hold the result until its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            m_valid_reg <= vld[NCELLS];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            result_reg <= result_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = result_reg;

endmodule

`default_nettype wire

FILE: rtl/s20ke_cell.sv
`default_nettype none

// One add-rotate-xor step of all four quarter-rounds of a column or row round.
module s20ke_cell
    import s20ke_pkg::*;
#(
    parameter bit          ROW_ROUND = 1'b0,
    parameter int unsigned STEP      = 0
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   ce,
    input  wire logic   in_valid,
    input  wire state_t in_state,
    input  wire seed_t  in_seed,
    output logic        out_valid,
    output state_t      out_state,
    output seed_t       out_seed
);

    localparam int unsigned TGT   = (STEP + 1) % 4;
    localparam int unsigned SRC_A = STEP % 4;
    localparam int unsigned SRC_B = (STEP + 3) % 4;
    localparam int unsigned SH    = ROT_AMT[STEP % 4];

    logic   valid_reg;
    state_t state_reg;
    state_t state_next;
    seed_t  seed_reg;

    // Update the target word of each quarter; the four touch disjoint words
    always_comb begin
        state_next = in_state;
        for (int q = 0; q < 4; q++) begin
            state_next[QIDX[ROW_ROUND][q][TGT]] =
                in_state[QIDX[ROW_ROUND][q][TGT]] ^
                rotl32(in_state[QIDX[ROW_ROUND][q][SRC_A]] +
                       in_state[QIDX[ROW_ROUND][q][SRC_B]], SH);
        end
    end

    // Track occupancy of this stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    // Advance payload with the pipeline
    always_ff @(posedge aclk) begin
        if (ce) begin
            state_reg <= state_next;
            seed_reg  <= in_seed;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
    assign out_seed  = seed_reg;

endmodule

`default_nettype wire

FILE: rtl/s20ke_checker.sv
`default_nettype none

`include "salsa20_key_expand_core_assert.svh"

module s20ke_checker
    import s20ke_pkg::*;
(
    input wire logic    aclk,
    input wire logic    aresetn,
    input wire logic    s_valid,
    input wire logic    s_ready,
    input wire logic    m_valid,
    input wire logic    m_ready,
    input wire result_t m_data
);

    // Reset empties the output stage
    `S20KE_ASSERT_NEXT_RST(a_reset_empty, aclk, !aresetn, !m_valid, "m_valid after reset")

    // Input side stalls only behind a result that is not taken
    `S20KE_ASSERT_IMPL(a_ready_rule, aclk, aresetn, 1'b1, s_ready == (!m_valid || m_ready),
        "s_ready does not follow output stage")

    // A stalled result stays offered, unchanged
    `S20KE_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid,
        "m_valid dropped before transfer")
    `S20KE_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_data),
        "m_data changed before transfer")

    // Nothing is accepted while a stalled result blocks the chain
    `S20KE_ASSERT_IMPL(a_no_accept_stall, aclk, aresetn, m_valid && !m_ready,
        !(s_valid && s_ready), "seed accepted while chain stalled")

endmodule

bind salsa20_key_expand_core s20ke_checker u_s20ke_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
